### rtl/dv_dif_error_block_marker_top_assert.svh
// assertion macros shared by the checker
`ifndef DV_DIF_ERROR_BLOCK_MARKER_TOP_ASSERT_SVH
`define DV_DIF_ERROR_BLOCK_MARKER_TOP_ASSERT_SVH

// property checked on every rising edge, held off while reset is low
`define DVDEM_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every rising edge, reset included
`define DVDEM_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/dvdem_pkg.sv
package dvdem_pkg;

  // block geometry
  localparam int BLOCK_LEN     = 80;
  localparam int PATTERN_LEN   = 76;
  localparam int HEADER_NIBBLE = 9;
  localparam int SIZE_BITS_DEF = 20;
  localparam int PKT_SIZE_W    = 20;

  // pattern bytes
  localparam logic [7:0] Y_TAG     = 8'h06;
  localparam logic [7:0] C_TAG     = 8'h16;
  localparam logic [7:0] FILL_BYTE = 8'hFF;

  // register reset values
  localparam logic [15:0] STA_MASK_RST = 16'hFFFE;
  localparam logic [7:0]  Y_DC_RST     = 8'd98;
  localparam logic [7:0]  V_DC_RST     = 8'd21;
  localparam logic [7:0]  U_DC_RST     = 8'd128;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_STA_MASK = 2'd0,
    REG_Y_DC     = 2'd1,
    REG_V_DC     = 2'd2,
    REG_U_DC     = 2'd3
  } cfg_reg_t;

  // DC values written into marked blocks
  typedef struct packed {
    logic [7:0] y;
    logic [7:0] v;
    logic [7:0] u;
  } dc_bytes_t;

  typedef enum logic [1:0] {
    DC_NONE = 2'd0,
    DC_Y    = 2'd1,
    DC_V    = 2'd2,
    DC_U    = 2'd3
  } dc_kind_t;

  // which DC byte, if any, sits at pattern index k
  function automatic dc_kind_t dc_kind(input logic [6:0] k);
    dc_kind_t kind;
    unique case (k)
      7'd0, 7'd10, 7'd14, 7'd20, 7'd28, 7'd30, 7'd42: kind = DC_Y;
      7'd40, 7'd50, 7'd56:                            kind = DC_V;
      7'd60, 7'd66, 7'd68:                            kind = DC_U;
      default:                                        kind = DC_NONE;
    endcase
    return kind;
  endfunction

endpackage

### rtl/dvdem_pattern.sv
module dvdem_pattern (
  input  logic [6:0]           k,
  input  dvdem_pkg::dc_bytes_t dc,
  output logic [7:0]           pat_byte
);
  import dvdem_pkg::*;

  dc_kind_t here;
  dc_kind_t prev;

  // kind of this byte and of the one before it
  always_comb begin
    here = dc_kind(k);
    prev = (k != 7'd0) ? dc_kind(k - 7'd1) : DC_NONE;
  end

  // DC byte, tag after a DC byte, or fill
  always_comb begin
    priority if (here == DC_Y) begin
      pat_byte = dc.y;
    end else if (here == DC_V) begin
      pat_byte = dc.v;
    end else if (here == DC_U) begin
      pat_byte = dc.u;
    end else if (prev == DC_Y) begin
      pat_byte = Y_TAG;
    end else if (prev == DC_V || prev == DC_U) begin
      pat_byte = C_TAG;
    end else begin
      pat_byte = FILL_BYTE;
    end
  end

endmodule

### rtl/dv_dif_error_block_marker_top.sv
// Marks damaged DV DIF blocks on a byte stream. Each packet is cut into 80-byte
// blocks counted from the byte flagged first_of_packet; a block that lies wholly
// inside the packet, has 9 in the high nibble of byte 0 and a status nibble in
// byte 3 whose sta_mask bit is set gets bytes 4 to 79 replaced by the fixed
// concealment pattern built from the y/v/u DC registers. One byte is taken per
// clock while in_stall is low, its result registered in the output register in
// the cycle after; in_stall rises only while that register holds a byte the far
// side has not taken. Registers are written through cfg_we/cfg_index/cfg_wdata;
// the user must write them only while no bytes are in flight (not enforced by
// the block). byte_offset saturates, so nothing is marked on very long streams.
module dv_dif_error_block_marker_top #(
  parameter int SIZE_BITS = dvdem_pkg::SIZE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       in_data_byte,
  input  logic                             in_first_of_packet,
  input  logic                             in_last_of_packet,
  input  logic [dvdem_pkg::PKT_SIZE_W-1:0] in_packet_size,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [7:0]                       out_byte,
  output logic                             out_last,
  output logic                             out_was_replaced,
  // configuration
  input  logic                             cfg_we,
  input  dvdem_pkg::cfg_reg_t              cfg_index,
  input  logic [15:0]                      cfg_wdata
);
  import dvdem_pkg::*;

  localparam int SUM_W = SIZE_BITS + 1;
  localparam logic [SIZE_BITS-1:0] OFF_MAX = {SIZE_BITS{1'b1}};

  // configuration registers
  logic [15:0] sta_mask_r;
  dc_bytes_t   dc_r;

  // block tracking state
  logic [SIZE_BITS-1:0] byte_offset_r, byte_offset_nxt;
  logic [6:0]           block_pos_r, block_pos_nxt;
  logic [SIZE_BITS-1:0] saved_size_r, saved_size_nxt;
  logic                 header_seen_r, header_seen_nxt;
  logic                 marked_r, marked_nxt;

  // result register
  logic       out_valid_r;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_last_r;
  logic       out_repl_r, out_repl_nxt;

  logic                 in_xfer;
  logic [SIZE_BITS-1:0] off;
  logic [6:0]           pos;
  logic [6:0]           pat_idx;
  logic [7:0]           pat_byte;
  logic [3:0]           nib;
  logic                 blk_fits;

  assign in_stall = out_valid_r && out_stall;
  assign in_xfer  = in_valid && !in_stall;
  assign nib      = in_data_byte[7:4];
  assign pat_idx  = pos - 7'd4;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sta_mask_r <= STA_MASK_RST;
      dc_r.y     <= Y_DC_RST;
      dc_r.v     <= V_DC_RST;
      dc_r.u     <= U_DC_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STA_MASK: sta_mask_r <= cfg_wdata;
        REG_Y_DC:     dc_r.y     <= cfg_wdata[7:0];
        REG_V_DC:     dc_r.v     <= cfg_wdata[7:0];
        REG_U_DC:     dc_r.u     <= cfg_wdata[7:0];
        default:      ;
      endcase
    end
  end

  // concealment pattern lookup
  dvdem_pattern u_pattern (
    .k        (pat_idx),
    .dc       (dc_r),
    .pat_byte (pat_byte)
  );

  // position within packet and block
  always_comb begin
    if (in_first_of_packet) begin
      off            = '0;
      pos            = 7'd0;
      saved_size_nxt = SIZE_BITS'(in_packet_size);
    end else begin
      off            = byte_offset_r;
      pos            = (block_pos_r >= 7'(BLOCK_LEN)) ? 7'd0 : block_pos_r;
      saved_size_nxt = saved_size_r;
    end
    blk_fits = (SUM_W'(off) + SUM_W'(BLOCK_LEN - 3)) <= SUM_W'(saved_size_nxt);
    byte_offset_nxt = (off == OFF_MAX) ? OFF_MAX : off + 1'b1;
    block_pos_nxt   = (pos == 7'(BLOCK_LEN - 1)) ? 7'd0 : pos + 7'd1;
  end

  // marking decision and byte replacement
  always_comb begin
    header_seen_nxt = header_seen_r;
    marked_nxt      = marked_r;
    out_byte_nxt    = in_data_byte;
    out_repl_nxt    = 1'b0;
    if (pos == 7'd0) begin
      header_seen_nxt = (nib == 4'(HEADER_NIBBLE));
      marked_nxt      = 1'b0;
    end else if (pos == 7'd3) begin
      marked_nxt = header_seen_r && sta_mask_r[nib] && blk_fits;
    end else if (pos >= 7'd4 && marked_r) begin
      out_byte_nxt = pat_byte;
      out_repl_nxt = 1'b1;
    end
  end

  // state update on each input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_offset_r <= '0;
      block_pos_r   <= 7'd0;
      saved_size_r  <= '0;
      header_seen_r <= 1'b0;
      marked_r      <= 1'b0;
    end else if (in_xfer) begin
      byte_offset_r <= byte_offset_nxt;
      block_pos_r   <= block_pos_nxt;
      saved_size_r  <= saved_size_nxt;
      header_seen_r <= header_seen_nxt;
      marked_r      <= marked_nxt;
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_byte_r <= out_byte_nxt;
      out_last_r <= in_last_of_packet;
      out_repl_r <= out_repl_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte         = out_byte_r;
  assign out_last         = out_last_r;
  assign out_was_replaced = out_repl_r;

endmodule

### rtl/dvdem_checker.sv
`include "dv_dif_error_block_marker_top_assert.svh"

module dvdem_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       in_first_of_packet,
  input logic       in_last_of_packet,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       out_last,
  input logic       out_was_replaced
);

  // input only held back by a pending result
  `DVDEM_ASSERT(a_stall_cause, clk, rst_n, in_stall |-> (out_valid && out_stall), "in_stall without a blocked result")

  // every input transfer leaves a result the next cycle
  `DVDEM_ASSERT(a_result_follows, clk, rst_n, (rst_n && in_valid && !in_stall) |=> (out_valid && out_last == $past(in_last_of_packet)), "result missing or last flag lost")

  // the first byte of a packet is never pattern
  `DVDEM_ASSERT(a_first_kept, clk, rst_n, (rst_n && in_valid && !in_stall && in_first_of_packet) |=> !out_was_replaced, "first byte of packet replaced")

  // stalled result holds
  `DVDEM_ASSERT(a_out_hold, clk, rst_n, (rst_n && out_valid && out_stall) |=> (out_valid && $stable(out_byte) && $stable(out_was_replaced)), "stalled result changed")

endmodule

bind dv_dif_error_block_marker_top dvdem_checker u_checker (.*);
